FILE: hw/rtl/sact_pkg.sv
// shared constants and controller/datapath interface types for the cache tag store
package sact_pkg;

    localparam int ADDR_W = 32;
    localparam int AGE_W  = 4;
    localparam int WAY_W  = 4;
    localparam int CNT_W  = 32;
    localparam int OUT_W  = 72;

    localparam logic [AGE_W-1:0] AGE_MAX = 4'hF;

    typedef struct packed {
        logic clr;
        logic rd;
        logic exec;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } ctl_sts_t;

endpackage

FILE: hw/rtl/sact_ctrl.sv
// sequencing controller: clearing pass, tag row read, update and result hand-off
module sact_ctrl
    import sact_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/sact_dp.sv
// datapath: tag/age row memory, hit and victim selection, counters and output register
module sact_dp
    import sact_pkg::*;
#(
    parameter int WAYS        = 4,
    parameter int SET_BITS    = 8,
    parameter int OFFSET_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_cmd_t          cmd,
    output ctl_sts_t          sts,
    input  logic [ADDR_W-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int TAG_W    = ADDR_W - SET_BITS - OFFSET_BITS;
    localparam int ENT_W    = TAG_W + AGE_W + 1;
    localparam int ROW_W    = WAYS * ENT_W;
    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int LVL      = $clog2(WAYS);
    localparam int P        = 1 << LVL;

    logic [ROW_W-1:0] mem [NUM_SETS];
    logic [ROW_W-1:0] rdata_reg;
    logic [ROW_W-1:0] wdata;
    logic [SET_BITS-1:0] waddr;
    logic we;

    logic [SET_BITS-1:0] clr_cnt_reg;
    logic [SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]    tag_reg;

    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_next;

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [WAY_W-1:0] out_way_reg;
    logic             out_evict_reg;
    logic [CNT_W-1:0] out_hits_reg;
    logic [CNT_W-1:0] out_misses_reg;

    logic [WAYS-1:0]  v;
    logic [TAG_W-1:0] t [WAYS];
    logic [AGE_W-1:0] a [WAYS];
    logic             hit;
    logic             any_empty;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] empty_way;
    logic [WAY_W-1:0] old_way;
    logic [WAY_W-1:0] chosen;
    logic [AGE_W-1:0] node_age [P];
    logic [WAY_W-1:0] node_idx [P];
    logic [ROW_W-1:0] new_row;

    // row memory, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[s_tdata[OFFSET_BITS +: SET_BITS]];
            set_reg   <= s_tdata[OFFSET_BITS +: SET_BITS];
            tag_reg   <= s_tdata[ADDR_W-1 -: TAG_W];
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            t[w] = rdata_reg[w*ENT_W +: TAG_W];
            a[w] = rdata_reg[w*ENT_W + TAG_W +: AGE_W];
            v[w] = rdata_reg[w*ENT_W + TAG_W + AGE_W];
        end
    end

    // first hit and first empty way, lowest index wins
    always_comb
    begin
        hit       = 1'b0;
        any_empty = 1'b0;
        hit_way   = '0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (v[w] && (t[w] == tag_reg))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!v[w])
            begin
                any_empty = 1'b1;
                empty_way = WAY_W'(w);
            end
        end
    end

    // oldest way by comparison tree, left side kept on a tie
    always_comb
    begin
        for (int i = 0; i < P; i++)
        begin
            node_age[i] = (i < WAYS) ? a[i] : '0;
            node_idx[i] = WAY_W'(i);
        end
        for (int l = 0; l < LVL; l++)
        begin
            for (int i = 0; i < P / 2; i++)
            begin
                if (i < (P >> (l + 1)))
                begin
                    if (node_age[2*i+1] > node_age[2*i])
                    begin
                        node_age[i] = node_age[2*i+1];
                        node_idx[i] = node_idx[2*i+1];
                    end
                    else
                    begin
                        node_age[i] = node_age[2*i];
                        node_idx[i] = node_idx[2*i];
                    end
                end
            end
        end
        old_way = node_idx[0];
    end

    assign chosen = hit ? hit_way : (any_empty ? empty_way : old_way);

    always_comb
    begin
        new_row = rdata_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == chosen)
            begin
                new_row[w*ENT_W +: ENT_W] = {1'b1, {AGE_W{1'b0}}, tag_reg};
            end
            else if (v[w])
            begin
                new_row[w*ENT_W + TAG_W +: AGE_W] = (a[w] < AGE_MAX) ? a[w] + 1'b1 : AGE_MAX;
            end
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = set_reg;
        wdata = new_row;
        if (cmd.clr)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else if (cmd.exec && !hit)
        begin
            we = 1'b1;
        end
    end

    assign hit_cnt_next  = hit ? hit_cnt_reg + 1'b1 : hit_cnt_reg;
    assign miss_cnt_next = hit ? miss_cnt_reg : miss_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_hit_reg    <= hit;
            out_way_reg    <= chosen;
            out_evict_reg  <= !hit && !any_empty;
            out_hits_reg   <= hit_cnt_next;
            out_misses_reg <= miss_cnt_next;
        end
    end

    assign sts.clr_last = (clr_cnt_reg == {SET_BITS{1'b1}});
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_misses_reg, out_hits_reg, out_evict_reg,
                       out_way_reg, out_hit_reg};

endmodule

FILE: hw/rtl/set_assoc_cache_tags_fifo.sv
// top level of the set-associative cache tag store with fifo replacement
//
// s_* carries read requests: s_tdata is the 32-bit byte address, the set taken
// from the bits above the offset and the tag from the bits above the set.
// m_* carries one result per request: hit flag, way hit or filled, eviction
// flag and the running hit and miss counts after this request.
// a request first reads the set's tag/age row from the row memory into a
// register, then chooses the way, writes the row back on a miss and loads the
// output register. the next request can be accepted in the cycle the result
// becomes valid, even while the result still waits.
// after reset a clearing pass walks all 2**SET_BITS rows of the row memory
// (256 at the defaults), one row a cycle, with s_tready low; counters are zero.
// when the receiver stalls with a result still held, the update of the
// following request waits until the output register frees up.
module set_assoc_cache_tags_fifo
    import sact_pkg::*;
#(
    parameter int WAYS        = 4,
    parameter int SET_BITS    = 8,
    parameter int OFFSET_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ADDR_W-1:0] s_tdata,   // address
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // hit, way[3:0], evicted, hit_total, miss_total, pad
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    sact_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sact_dp #(
        .WAYS        (WAYS),
        .SET_BITS    (SET_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: hw/rtl/sact_chk.sv
// port-level checks for the cache tag store, bound to the top level
module sact_chk
    import sact_pkg::*;
#(
    parameter int WAYS = 4
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata
);

    // held result stays put while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result once reset has been seen
    a_rst: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // one request in flight: no acceptance right after an acceptance
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted back to back");

    // a hit never evicts
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[5])
        else $error("eviction reported on a hit");

    // way index stays inside the set
    a_way: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:1] <= WAY_W'(WAYS - 1)))
        else $error("way index out of range");

endmodule

bind set_assoc_cache_tags_fifo sact_chk #(.WAYS(WAYS)) u_sact_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
